### design/iirbpf_pkg.sv
// ----------------------------------------------------------------------------
// iirbpf_pkg
// Shared widths, defaults, codes and types of the IIR band-pass filter bank.
// ----------------------------------------------------------------------------
package iirbpf_pkg;

  localparam int DEF_NUM_FILTERS = 16;
  localparam int DEF_TAPS        = 4;

  localparam int SAMP_W  = 24;   // Q1.23 sample / output
  localparam int COEF_W  = 32;   // Q8.24 coefficient / delay
  localparam int ID_W    = 6;
  localparam int TAP_W   = 5;
  localparam int PROD_W  = 2 * COEF_W;
  localparam int ACC_W   = 48;   // holds 17 rounded products plus the sample
  localparam int FRAC_W  = 24;

  // op field codes
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // coeff_kind field codes
  localparam logic KIND_NUM = 1'b0;
  localparam logic KIND_DEN = 1'b1;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic valid;   // operands present this cycle
  } mac_ctrl_t;

endpackage

### design/iirbpf_if.sv
// ----------------------------------------------------------------------------
// iirbpf_if
// Valid/ready channels for input items and filter results.
// ----------------------------------------------------------------------------
interface iirbpf_in_if;
  import iirbpf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [SAMP_W-1:0] sample_in;
  logic [ID_W-1:0]          filter_sel;
  logic                     coeff_kind;
  logic [TAP_W-1:0]         tap_sel;
  logic signed [COEF_W-1:0] coeff_value;

  modport source (output valid, op, sample_in, filter_sel, coeff_kind, tap_sel,
                  coeff_value, input ready);
  modport sink   (input valid, op, sample_in, filter_sel, coeff_kind, tap_sel,
                  coeff_value, output ready);
endinterface

interface iirbpf_out_if;
  import iirbpf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ID_W-1:0]          filter_id;
  logic signed [SAMP_W-1:0] filtered_value;
  logic                     last;

  modport source (output valid, filter_id, filtered_value, last, input ready);
  modport sink   (input valid, filter_id, filtered_value, last, output ready);
endinterface

### design/iirbpf_ram.sv
// ----------------------------------------------------------------------------
// iirbpf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module iirbpf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/iirbpf_mac.sv
// ----------------------------------------------------------------------------
// iirbpf_mac
// Shared multiply-accumulate unit: Q8.24 x Q8.24, rounded back to Q8.24.
// Multiply, round and accumulate each take one register stage.
// ----------------------------------------------------------------------------
module iirbpf_mac
  import iirbpf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [COEF_W-1:0] opa,
  input  logic signed [COEF_W-1:0] opb,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     busy
);

  localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(64'sd1 <<< (FRAC_W - 1));

  logic                     prod_v;
  logic                     rnd_v;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [ACC_W-1:0]  rnd;

  assign rnd_sum = prod + ROUND;
  assign busy    = prod_v | rnd_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
      rnd_v  <= 1'b0;
    end else begin
      prod_v <= ctrl.valid;
      rnd_v  <= prod_v;
    end
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
    // floor shift of the rounded product
    rnd  <= ACC_W'($signed(rnd_sum[PROD_W-1:FRAC_W]));
    if (ctrl.clear) begin
      acc <= '0;
    end else if (rnd_v) begin
      acc <= acc + rnd;
    end
  end

endmodule

### design/iir_bandpass_filter_bank.sv
// ----------------------------------------------------------------------------
// iir_bandpass_filter_bank
// Bank of direct-form-II IIR filters sharing one sample, one MAC unit.
// ----------------------------------------------------------------------------
// A sample beat (op = 0) runs every filter in turn through one shared
// multiply-accumulate unit and returns NUM_FILTERS result beats in filter
// order, last set on the final one. Per filter the sequencer first sums
// a[k]*d[k] over TAPS delays, forms w = 2*x - sum saturated to 32 bits, then
// sums b0*w + b[k+1]*d[k]; the Q8.24 result is rounded and saturated to Q1.23.
// For each filter the sequencer issues the TAPS feedback products, drains the
// MAC (memory read, multiply, round, accumulate registers), forms w, issues
// the TAPS+1 output products, drains the MAC again and hands off the result;
// it waits in that last step while the result register is still full. A
// coefficient beat (op = 1) is written in its accept cycle; loads to a filter
// or tap out of range are dropped. Coefficients must be loaded before use.
// After reset the delay memory is cleared one entry per cycle, and no beat is
// accepted until the clear is done. The delay lines are circular: all filters
// share one head index that steps back once per sample.
// ----------------------------------------------------------------------------
module iir_bandpass_filter_bank
  import iirbpf_pkg::*;
#(
  parameter int NUM_FILTERS = DEF_NUM_FILTERS,  // 1..64
  parameter int TAPS        = DEF_TAPS          // 2..16
) (
  input  logic         clk,
  input  logic         rst,
  iirbpf_in_if.sink    items,
  iirbpf_out_if.source results
);

  localparam int DL  = NUM_FILTERS * TAPS;         // delay / denominator depth
  localparam int NL  = NUM_FILTERS * (TAPS + 1);   // numerator depth
  localparam int DAW = $clog2(DL);
  localparam int NAW = $clog2(NL);
  localparam int FW  = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int KW  = $clog2(TAPS + 1);
  localparam int TPW = $clog2(TAPS);
  localparam int NUM_STRIDE = TAPS + 1;

  localparam logic signed [ACC_W-1:0] W_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] W_MIN = ACC_W'(-64'sd2147483648);
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(64'sd8388607);
  localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-64'sd8388608);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,   // zero the delay memory after reset
    S_IDLE  = 8'b0000_0010,
    S_DEN   = 8'b0000_0100,   // issue a[k]*d[k]
    S_DWAIT = 8'b0000_1000,   // drain MAC
    S_W     = 8'b0001_0000,   // w = 2x - acc, saturated
    S_NUM   = 8'b0010_0000,   // issue b0*w, b[k+1]*d[k]
    S_NWAIT = 8'b0100_0000,   // drain MAC
    S_OUT   = 8'b1000_0000    // hand result to output register
  } state_t;

  state_t state;
  state_t state_next;

  // sequencer registers
  logic [DAW-1:0]           clr_addr;
  logic [TPW-1:0]           head;
  logic [TPW-1:0]           ptr;
  logic [KW-1:0]            k;
  logic [FW-1:0]            f;
  logic [DAW-1:0]           dbase;
  logic [NAW-1:0]           nbase;
  logic signed [SAMP_W-1:0] x;
  logic signed [COEF_W-1:0] w;
  logic                     rd_v;
  logic                     rd_num;
  logic                     rd_usew;

  // output register
  logic                     out_valid;
  logic [ID_W-1:0]          out_id;
  logic signed [SAMP_W-1:0] out_value;
  logic                     out_last;

  // memories
  logic              num_we;
  logic [NAW-1:0]    num_waddr;
  logic [NAW-1:0]    num_raddr;
  logic [COEF_W-1:0] num_q;
  logic              den_we;
  logic [DAW-1:0]    den_waddr;
  logic [DAW-1:0]    den_raddr;
  logic [COEF_W-1:0] den_q;
  logic              dly_we;
  logic [DAW-1:0]    dly_waddr;
  logic [COEF_W-1:0] dly_wdata;
  logic [DAW-1:0]    dly_raddr;
  logic [COEF_W-1:0] dly_q;

  // MAC
  mac_ctrl_t                mac_ctrl;
  logic signed [COEF_W-1:0] mac_a;
  logic signed [COEF_W-1:0] mac_b;
  logic signed [ACC_W-1:0]  acc;
  logic                     mac_busy;

  // datapath helpers
  logic                     in_fire;
  logic                     sel_ok;
  logic                     issue;
  logic                     drained;
  logic                     out_free;
  logic                     out_load;
  logic                     f_last;
  logic                     k_den_end;
  logic                     k_num_end;
  logic [TPW-1:0]           ptr_inc;
  logic [TPW-1:0]           head_prev;
  logic signed [ACC_W-1:0]  x2;
  logic signed [ACC_W-1:0]  w_diff;
  logic signed [COEF_W-1:0] w_sat;
  logic signed [ACC_W-1:0]  y_sum;
  logic signed [ACC_W-1:0]  y_half;
  logic signed [SAMP_W-1:0] y_sat;

  assign items.ready = (state == S_IDLE);
  assign in_fire     = items.valid && items.ready;

  assign results.valid          = out_valid;
  assign results.filter_id      = out_id;
  assign results.filtered_value = out_value;
  assign results.last           = out_last;

  assign f_last    = (f == FW'(NUM_FILTERS - 1));
  assign k_den_end = (k == KW'(TAPS - 1));
  assign k_num_end = (k == KW'(TAPS));
  assign ptr_inc   = (ptr == TPW'(TAPS - 1)) ? '0 : ptr + 1'b1;
  // slot of the oldest delay, reused for the new w after the head steps back
  assign head_prev = (head == '0) ? TPW'(TAPS - 1) : head - 1'b1;
  assign drained   = !rd_v && !mac_busy;
  assign out_free  = !out_valid || results.ready;
  assign out_load  = (state == S_OUT) && out_free;
  assign issue     = (state == S_DEN) || (state == S_NUM);

  // ---------------------------------------------------------------- coefficient loads
  assign sel_ok    = {1'b0, items.filter_sel} < (ID_W + 1)'(NUM_FILTERS);
  assign num_we    = in_fire && (items.op == OP_LOAD) && sel_ok &&
                     (items.coeff_kind == KIND_NUM) && (items.tap_sel <= TAP_W'(TAPS));
  assign den_we    = in_fire && (items.op == OP_LOAD) && sel_ok &&
                     (items.coeff_kind == KIND_DEN) && (items.tap_sel < TAP_W'(TAPS));
  assign num_waddr = NAW'(32'(items.filter_sel) * NUM_STRIDE + 32'(items.tap_sel));
  assign den_waddr = DAW'(32'(items.filter_sel) * TAPS + 32'(items.tap_sel));

  // ---------------------------------------------------------------- read addresses
  // Denominator is in natural order, delays rotate with the shared head.
  assign num_raddr = nbase + NAW'(k);
  assign den_raddr = dbase + DAW'(k);
  assign dly_raddr = dbase + DAW'(ptr);

  // ---------------------------------------------------------------- delay writes
  always_comb begin
    dly_we    = 1'b0;
    dly_waddr = dbase + DAW'(head_prev);
    dly_wdata = w;
    if (state == S_CLEAR) begin
      dly_we    = 1'b1;
      dly_waddr = clr_addr;
      dly_wdata = '0;
    end else if (out_load) begin
      dly_we    = 1'b1;
    end
  end

  iirbpf_ram #(.DEPTH(NL), .WIDTH(COEF_W), .AW(NAW)) u_num_ram (
    .clk   (clk),
    .we    (num_we),
    .waddr (num_waddr),
    .wdata (items.coeff_value),
    .raddr (num_raddr),
    .rdata (num_q)
  );

  iirbpf_ram #(.DEPTH(DL), .WIDTH(COEF_W), .AW(DAW)) u_den_ram (
    .clk   (clk),
    .we    (den_we),
    .waddr (den_waddr),
    .wdata (items.coeff_value),
    .raddr (den_raddr),
    .rdata (den_q)
  );

  iirbpf_ram #(.DEPTH(DL), .WIDTH(COEF_W), .AW(DAW)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (dly_wdata),
    .raddr (dly_raddr),
    .rdata (dly_q)
  );

  // ---------------------------------------------------------------- MAC
  // Operands arrive in the cycle after issue; b0 pairs with w instead of a delay.
  assign mac_ctrl.valid = rd_v;
  assign mac_ctrl.clear = issue && (k == '0);
  assign mac_a = rd_num  ? $signed(num_q) : $signed(den_q);
  assign mac_b = rd_usew ? w : $signed(dly_q);

  iirbpf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .opa  (mac_a),
    .opb  (mac_b),
    .acc  (acc),
    .busy (mac_busy)
  );

  // ---------------------------------------------------------------- w and y
  assign x2     = {{(ACC_W - SAMP_W - 1){x[SAMP_W-1]}}, x, 1'b0};
  assign w_diff = x2 - acc;
  always_comb begin
    if (w_diff > W_MAX) begin
      w_sat = COEF_W'(W_MAX);
    end else if (w_diff < W_MIN) begin
      w_sat = COEF_W'(W_MIN);
    end else begin
      w_sat = COEF_W'(w_diff);
    end
  end

  // Q8.24 -> Q1.23 with round half up
  assign y_sum  = acc + ACC_W'(1);
  assign y_half = y_sum >>> 1;
  always_comb begin
    if (y_half > Y_MAX) begin
      y_sat = SAMP_W'(Y_MAX);
    end else if (y_half < Y_MIN) begin
      y_sat = SAMP_W'(Y_MIN);
    end else begin
      y_sat = SAMP_W'(y_half);
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == DAW'(DL - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire && (items.op == OP_FILTER)) begin
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        if (k_den_end) begin
          state_next = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (drained) begin
          state_next = S_W;
        end
      end
      S_W: begin
        state_next = S_NUM;
      end
      S_NUM: begin
        if (k_num_end) begin
          state_next = S_NWAIT;
        end
      end
      S_NWAIT: begin
        if (drained) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = f_last ? S_IDLE : S_DEN;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      head     <= '0;
      ptr      <= '0;
      k        <= '0;
      f        <= '0;
      dbase    <= '0;
      nbase    <= '0;
      rd_v     <= 1'b0;
      rd_num   <= 1'b0;
      rd_usew  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_v    <= issue;
      rd_num  <= (state == S_NUM);
      rd_usew <= (state == S_NUM) && (k == '0);

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        S_IDLE: begin
          if (in_fire && (items.op == OP_FILTER)) begin
            f     <= '0;
            dbase <= '0;
            nbase <= '0;
            k     <= '0;
            ptr   <= head;
          end
        end
        S_DEN: begin
          ptr <= ptr_inc;
          k   <= k_den_end ? '0 : k + 1'b1;
        end
        S_NUM: begin
          // b0 pairs with w, so the delay pointer holds on the first issue
          if (k != '0) begin
            ptr <= ptr_inc;
          end
          k <= k_num_end ? '0 : k + 1'b1;
        end
        S_OUT: begin
          if (out_free) begin
            if (f_last) begin
              head <= head_prev;
            end else begin
              f     <= f + 1'b1;
              dbase <= dbase + DAW'(TAPS);
              nbase <= nbase + NAW'(NUM_STRIDE);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sample and w: payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x <= items.sample_in;
    end
    if (state == S_W) begin
      w <= w_sat;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id    <= ID_W'(f);
      out_value <= y_sat;
      out_last  <= f_last;
    end
  end

endmodule

### design/iirbpf_chk.sv
// ----------------------------------------------------------------------------
// iirbpf_chk
// Port-level checks of the filter bank, bound to the top level.
// ----------------------------------------------------------------------------
module iirbpf_chk
  import iirbpf_pkg::*;
#(
  parameter int NUM_FILTERS = DEF_NUM_FILTERS
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_op,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ID_W-1:0]   out_id,
  input logic [SAMP_W-1:0] out_value,
  input logic              out_last
);

  logic [ID_W-1:0] exp_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_id <= '0;
    end else if (out_valid && out_ready) begin
      exp_id <= out_last ? '0 : exp_id + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_value)
      && $stable(out_last))
    else $error("result beat changed while stalled");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_op == OP_FILTER) |=> !in_ready)
    else $error("input taken while a sample is in work");

  a_id_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_id == exp_id)
    else $error("results out of filter order");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_last == (out_id == ID_W'(NUM_FILTERS - 1)))
    else $error("last flag does not match final filter");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("ports active right after reset");

endmodule

bind iir_bandpass_filter_bank iirbpf_chk #(.NUM_FILTERS(NUM_FILTERS)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_op     (items.op),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_id    (results.filter_id),
  .out_value (results.filtered_value),
  .out_last  (results.last)
);

### test/iir_bandpass_filter_bank_tb.sv
// ----------------------------------------------------------------------------
// iir_bandpass_filter_bank_tb
// Self-checking bench for the IIR filter bank. A queue of beats (coefficient
// loads and samples) is filled up front and driven with bursts and gaps; the
// result channel is stalled on a rotating pattern. A bit-true fixed-point
// model of the bank predicts every output, and each result beat is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module iir_bandpass_filter_bank_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iirbpf_pkg::*;

  localparam int NF             = DEF_NUM_FILTERS;
  localparam int NT             = DEF_TAPS;
  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 10;
  // quiet cycles after the last output before a coefficient beat goes out
  localparam int SETTLE_CYCLES  = 4;
  // one full sample pass plus margin: any stray output shows up in here
  localparam int DRAIN_CYCLES   = NF * (2 * NT + 11) + 16;
  localparam int TIMEOUT_CYCLES = 800_000;
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << FRAC_W;  // 1.0 in Q8.24
  localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
  localparam logic signed [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [SAMP_W-1:0] SAMP_MAX  = {1'b0, {(SAMP_W-1){1'b1}}};
  localparam logic signed [SAMP_W-1:0] SAMP_MIN  = {1'b1, {(SAMP_W-1){1'b0}}};

  localparam longint W_MAX = (longint'(1) << 31) - 1;
  localparam longint W_MIN = -(longint'(1) << 31);
  localparam longint Y_MAX = (longint'(1) << (SAMP_W - 1)) - 1;
  localparam longint Y_MIN = -(longint'(1) << (SAMP_W - 1));

  // how a whole coefficient bank is filled
  typedef enum int {
    BANK_PASS,  // b0 = 1.0, everything else 0: output equals input
    BANK_MILD,  // stable filters, |a| <= 0.25, |b| <= 1.0
    BANK_WILD   // extremes and full-range values, saturation everywhere
  } bank_style_t;

  typedef struct {
    logic                     op;
    logic signed [SAMP_W-1:0] sample;
    logic [ID_W-1:0]          fsel;
    logic                     kind;
    logic [TAP_W-1:0]         tap;
    logic signed [COEF_W-1:0] coeff;
  } bank_beat_t;

  typedef struct {
    logic [ID_W-1:0]          id;
    logic signed [SAMP_W-1:0] value;
    logic                     last;
  } filter_out_t;

  logic clk = 1'b0;
  logic rst;

  iirbpf_in_if  items_ch();
  iirbpf_out_if results_ch();

  iir_bandpass_filter_bank #(
    .NUM_FILTERS(NF),
    .TAPS       (NT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_ch),
    .results(results_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // Filter bank model: coefficients, delay lines and expected outputs
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] b_coef     [NF][NT+1];
  logic signed [COEF_W-1:0] a_coef     [NF][NT];
  logic signed [COEF_W-1:0] delay_line [NF][NT];

  bank_beat_t  tx_beats[$];        // beats still to be driven
  filter_out_t bank_outputs_q[$];  // predicted outputs, oldest first

  int   mismatches    = 0;
  int   samples_done  = 0;
  int   loads_applied = 0;
  int   loads_dropped = 0;
  int   outputs_seen  = 0;
  int   sat_outputs   = 0;
  int   sat_states    = 0;
  logic in_taken;       // input beat accepted at the last rising edge
  int   idle_cycles;    // rising edges with no output outstanding

  // Q8.24 x Q8.24, exact product rounded half up back to Q8.24
  function automatic longint q24_mul(logic signed [COEF_W-1:0] p,
                                     logic signed [COEF_W-1:0] q);
    longint prod;
    prod = longint'(p) * longint'(q);
    return (prod + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic void write_coeff(bank_beat_t bt);
    if (bt.fsel >= NF) begin
      loads_dropped++;
    end else if (bt.kind == KIND_NUM && bt.tap <= NT) begin
      b_coef[bt.fsel][bt.tap] = bt.coeff;
      loads_applied++;
    end else if (bt.kind == KIND_DEN && bt.tap < NT) begin
      a_coef[bt.fsel][bt.tap] = bt.coeff;
      loads_applied++;
    end else begin
      loads_dropped++;
    end
  endfunction

  // one sample through every filter; pushes NF predicted outputs
  function automatic void run_filters(logic signed [SAMP_W-1:0] x_in);
    longint                   x2, fb_sum, w_full, y_acc, y_rnd;
    logic signed [COEF_W-1:0] w;
    filter_out_t              o;
    x2 = longint'(x_in) * 2;  // Q1.23 -> Q8.24
    for (int f = 0; f < NF; f++) begin
      fb_sum = 0;
      for (int k = 0; k < NT; k++)
        fb_sum += q24_mul(a_coef[f][k], delay_line[f][k]);
      w_full = x2 - fb_sum;
      if (w_full > W_MAX || w_full < W_MIN) begin
        sat_states++;
        w_full = (w_full > W_MAX) ? W_MAX : W_MIN;
      end
      w = w_full[COEF_W-1:0];
      y_acc = q24_mul(b_coef[f][0], w);
      for (int k = 0; k < NT; k++)
        y_acc += q24_mul(b_coef[f][k+1], delay_line[f][k]);
      y_rnd = (y_acc + 1) >>> 1;  // Q8.24 -> Q1.23
      if (y_rnd > Y_MAX || y_rnd < Y_MIN) begin
        sat_outputs++;
        y_rnd = (y_rnd > Y_MAX) ? Y_MAX : Y_MIN;
      end
      for (int k = NT - 1; k > 0; k--)
        delay_line[f][k] = delay_line[f][k-1];
      delay_line[f][0] = w;
      o.id    = ID_W'(f);
      o.value = y_rnd[SAMP_W-1:0];
      o.last  = (f == NF - 1);
      bank_outputs_q.push_back(o);
    end
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: mismatch %0d: %s", $realtime, mismatches, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [COEF_W-1:0] pick_coeff(bank_style_t style, logic kind);
    int span;
    if (style == BANK_WILD) begin
      case ($urandom_range(0, 4))
        0:       return COEF_MIN;
        1:       return COEF_MAX;
        2:       return COEF_ZERO;
        3:       return -1;
        default: return COEF_W'($urandom);
      endcase
    end
    span = (kind == KIND_DEN) ? (1 << 22) : (1 << 24);
    return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [SAMP_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      8:       return SAMP_MAX;
      9:       return SAMP_MIN;
      6, 7:    return SAMP_W'(int'($urandom_range(0, 131072)) - 65536);
      default: return SAMP_W'($urandom);
    endcase
  endfunction

  // unused fields of a beat carry random bits so every input bit toggles
  function automatic void queue_load(int fsel, logic kind, int tap,
                                     logic signed [COEF_W-1:0] val);
    bank_beat_t bt;
    bt.op     = OP_LOAD;
    bt.sample = SAMP_W'($urandom);
    bt.fsel   = ID_W'(fsel);
    bt.kind   = kind;
    bt.tap    = TAP_W'(tap);
    bt.coeff  = val;
    tx_beats.push_back(bt);
  endfunction

  function automatic void queue_sample(logic signed [SAMP_W-1:0] x);
    bank_beat_t bt;
    bt.op     = OP_FILTER;
    bt.sample = x;
    bt.fsel   = ID_W'($urandom);
    bt.kind   = 1'($urandom);
    bt.tap    = TAP_W'($urandom);
    bt.coeff  = COEF_W'($urandom);
    tx_beats.push_back(bt);
  endfunction

  // writes every coefficient of every filter, so nothing is read unwritten
  function automatic void load_bank(bank_style_t style);
    for (int f = 0; f < NF; f++) begin
      for (int t = 0; t <= NT; t++) begin
        if (style == BANK_PASS)
          queue_load(f, KIND_NUM, t, (t == 0) ? COEF_ONE : COEF_ZERO);
        else
          queue_load(f, KIND_NUM, t, pick_coeff(style, KIND_NUM));
      end
      for (int t = 0; t < NT; t++)
        queue_load(f, KIND_DEN, t,
                   (style == BANK_PASS) ? COEF_ZERO : pick_coeff(style, KIND_DEN));
    end
  endfunction

  // mostly samples, some single coefficient updates, a few dropped loads;
  // dropped loads don't count toward n
  function automatic void queue_random_items(int n);
    int          done;
    int          pick;
    logic        kind;
    bank_style_t style;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      kind = 1'($urandom_range(0, 1));
      if (pick < 25) begin
        style = ($urandom_range(0, 3) == 0) ? BANK_WILD : BANK_MILD;
        queue_load($urandom_range(0, NF - 1), kind,
                   (kind == KIND_NUM) ? $urandom_range(0, NT) : $urandom_range(0, NT - 1),
                   pick_coeff(style, kind));
        done++;
      end else if (pick < 29) begin
        if ($urandom_range(0, 1))
          queue_load($urandom_range(NF, 63), kind, $urandom_range(0, 31), COEF_W'($urandom));
        else
          queue_load($urandom_range(0, NF - 1), kind,
                     (kind == KIND_NUM) ? $urandom_range(NT + 1, 31) : $urandom_range(NT, 31),
                     COEF_W'($urandom));
      end else begin
        queue_sample(random_sample());
        done++;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. Input beats feed the
  // model, output beats are checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    filter_out_t want;
    bank_beat_t  seen;
    if (rst) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
      for (int f = 0; f < NF; f++) begin
        for (int k = 0; k < NT; k++) begin
          delay_line[f][k] = '0;
          a_coef[f][k]     = '0;
        end
        for (int k = 0; k <= NT; k++)
          b_coef[f][k] = '0;
      end
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        if (bank_outputs_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected output beat: id %0d value %0d last %0b",
                                  results_ch.filter_id, results_ch.filtered_value,
                                  results_ch.last));
        end else begin
          want = bank_outputs_q.pop_front();
          outputs_seen++;
          if (results_ch.filter_id !== want.id ||
              results_ch.filtered_value !== want.value ||
              results_ch.last !== want.last)
            flag_mismatch($sformatf({"expected id %0d value %0d last %0b, ",
                                     "got id %0d value %0d last %0b"},
                                    want.id, want.value, want.last,
                                    results_ch.filter_id, results_ch.filtered_value,
                                    results_ch.last));
        end
      end
      if (items_ch.valid && items_ch.ready) begin
        seen.op     = items_ch.op;
        seen.sample = items_ch.sample_in;
        seen.fsel   = items_ch.filter_sel;
        seen.kind   = items_ch.coeff_kind;
        seen.tap    = items_ch.tap_sel;
        seen.coeff  = items_ch.coeff_value;
        if (seen.op == OP_LOAD) begin
          write_coeff(seen);
        end else begin
          run_filters(seen.sample);
          samples_done++;
        end
      end
      in_taken <= items_ch.valid && items_ch.ready;
      if (bank_outputs_q.size() != 0)
        idle_cycles <= 0;
      else if (idle_cycles < 1000)
        idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: updates the input channel at the falling edge. A beat stays on the
  // bus until taken. Between some bursts the sender idles. Coefficient beats wait
  // until every predicted output has been drained and the bank has settled,
  // which also makes the sender hold off behind each sample pass.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    bank_beat_t nxt;
    if (rst) begin
      items_ch.valid <= 1'b0;
    end else begin
      if (in_taken)
        void'(tx_beats.pop_front());
      if (items_ch.valid && !in_taken) begin
        // beat still pending, hold it
      end else if (gap_left > 0) begin
        items_ch.valid <= 1'b0;
        gap_left--;
      end else if (tx_beats.size() == 0 ||
                   (tx_beats[0].op == OP_LOAD && idle_cycles < SETTLE_CYCLES)) begin
        items_ch.valid <= 1'b0;
      end else begin
        nxt = tx_beats[0];
        items_ch.valid       <= 1'b1;
        items_ch.op          <= nxt.op;
        items_ch.sample_in   <= nxt.sample;
        items_ch.filter_sel  <= nxt.fsel;
        items_ch.coeff_kind  <= nxt.kind;
        items_ch.tap_sel     <= nxt.tap;
        items_ch.coeff_value <= nxt.coeff;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          case ($urandom_range(0, 7))
            0: begin  // long stretch with no idling
              burst_left = 200;
              gap_left   = 0;
            end
            1, 2: begin
              burst_left = $urandom_range(1, 16);
              gap_left   = 0;
            end
            default: begin
              burst_left = $urandom_range(1, 24);
              gap_left   = $urandom_range(1, 12);
            end
          endcase
        end
      end
    end
  end

  // Receiver: ready follows a 16-bit pattern, renewed each time the index wraps.
  // Bit 0 is always set, so ready is high at least once per pass through it.
  logic [15:0] stall_pattern;
  logic [3:0]  stall_idx;

  always @(negedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
      stall_pattern    <= '1;
      stall_idx        <= '0;
    end else begin
      results_ch.ready <= stall_pattern[stall_idx];
      stall_idx        <= stall_idx + 1'b1;
      if (stall_idx == 4'hF)
        stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed beats, one random phase, drain, verdict
  // --------------------------------------------------------------------------
  initial begin
    rst                  = 1'b1;
    items_ch.valid       = 1'b0;
    items_ch.op          = OP_FILTER;
    items_ch.sample_in   = '0;
    items_ch.filter_sel  = '0;
    items_ch.coeff_kind  = KIND_NUM;
    items_ch.tap_sel     = '0;
    items_ch.coeff_value = '0;
    results_ch.ready     = 1'b0;

    // Pass-through bank first: every output must echo its input exactly.
    load_bank(BANK_PASS);
    queue_sample(0);
    queue_sample(SAMP_MAX);
    queue_sample(SAMP_MIN);
    queue_sample(-1);
    queue_sample(1);
    queue_sample(24'h555555);
    queue_sample(24'hAAAAAA);

    // Loads aimed outside the bank or past the last tap must change nothing.
    queue_load(NF, KIND_NUM, 0, COEF_MAX);
    queue_load(63, KIND_DEN, 0, COEF_MIN);
    queue_load(0, KIND_NUM, NT + 1, COEF_MAX);
    queue_load(0, KIND_DEN, NT, COEF_MAX);
    queue_load(NF - 1, KIND_NUM, 31, COEF_MIN);
    queue_load(NF - 1, KIND_DEN, 31, COEF_MIN);

    // Extreme coefficients: big gain saturates the output, big feedback
    // drives the state value into its clamp.
    queue_load(0, KIND_NUM, 0, COEF_MAX);
    queue_load(NF - 1, KIND_NUM, NT, COEF_MIN);
    queue_load(1, KIND_DEN, NT - 1, COEF_MAX);
    queue_load(2, KIND_DEN, 0, COEF_MIN);
    queue_sample(SAMP_MAX);
    queue_sample(SAMP_MIN);
    queue_sample(SAMP_MAX);
    queue_sample(12345);
    queue_sample(-1);

    // single coefficient updates mixed in with samples
    queue_random_items(85);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (tx_beats.size() != 0 || bank_outputs_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d samples, %0d outputs checked (%0d clipped outputs, %0d clamped states)",
             samples_done, outputs_seen, sat_outputs, sat_states);
    $display("coefficient beats: %0d written, %0d dropped as out of range; %0d mismatches",
             loads_applied, loads_dropped, mismatches);
    if (mismatches == 0 && bank_outputs_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("timeout: %0d beats unsent, %0d outputs outstanding",
             tx_beats.size(), bank_outputs_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### iir_bandpass_filter_bank.f
design/iirbpf_pkg.sv
design/iirbpf_if.sv
design/iirbpf_ram.sv
design/iirbpf_mac.sv
design/iir_bandpass_filter_bank.sv
design/iirbpf_chk.sv
test/iir_bandpass_filter_bank_tb.sv
